// ===== src/tibd_pkg.sv =====
// tibd_pkg: shared types and codes of the tape image block deframer
// holds the phase codes, result kinds, error codes and the result struct
// no dependencies
package tibd_pkg;

    // field widths
    localparam int KIND_W  = 3;
    localparam int WHERE_W = 16;
    localparam int BYTE_W  = 8;
    localparam int ERR_W   = 3;
    localparam int CNT_W   = 16;
    localparam int PHASE_W = 5;
    localparam int LEFT_W  = 9;
    localparam int NPOS_W  = 5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NAME_CHR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DATA     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RUN      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FINISH   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_HEADER     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_OUTER_TYPE = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TAPE_TYPE  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NAME_LONG  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_GAP        = 3'd4;
    localparam logic [ERR_W-1:0] ERR_OVERRUN    = 3'd5;

    // block type bytes
    localparam logic [BYTE_W-1:0] BYTE_HEADER   = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_OUTER    = 8'h55;
    localparam logic [BYTE_W-1:0] BYTE_OUTER_LAST = 8'hAA;
    localparam logic [BYTE_W-1:0] BYTE_NAME_A   = 8'h83;
    localparam logic [BYTE_W-1:0] BYTE_NAME_B   = 8'h87;
    localparam logic [BYTE_W-1:0] BYTE_DATA     = 8'hF9;
    localparam logic [BYTE_W-1:0] BYTE_CLOSE    = 8'hB9;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_HDR       = 5'd0;
    localparam logic [PHASE_W-1:0] PH_LEN_L     = 5'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_H     = 5'd2;
    localparam logic [PHASE_W-1:0] PH_OTYPE     = 5'd3;
    localparam logic [PHASE_W-1:0] PH_OSIZE_L   = 5'd4;
    localparam logic [PHASE_W-1:0] PH_OSIZE_H   = 5'd5;
    localparam logic [PHASE_W-1:0] PH_TTYPE     = 5'd6;
    localparam logic [PHASE_W-1:0] PH_NAME_IDX  = 5'd7;
    localparam logic [PHASE_W-1:0] PH_NAME_LEN  = 5'd8;
    localparam logic [PHASE_W-1:0] PH_NAME_CHR  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_NAME_CRC  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_DATA_IDX  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_ADDR_L    = 5'd12;
    localparam logic [PHASE_W-1:0] PH_ADDR_H    = 5'd13;
    localparam logic [PHASE_W-1:0] PH_COUNT     = 5'd14;
    localparam logic [PHASE_W-1:0] PH_DATA_BYTE = 5'd15;
    localparam logic [PHASE_W-1:0] PH_DATA_CRC  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_CLOSE_IDX = 5'd17;
    localparam logic [PHASE_W-1:0] PH_RUN_L     = 5'd18;
    localparam logic [PHASE_W-1:0] PH_RUN_H     = 5'd19;
    localparam logic [PHASE_W-1:0] PH_CLOSE_CRC = 5'd20;
    localparam logic [PHASE_W-1:0] PH_BAD_IDX   = 5'd21;
    localparam logic [PHASE_W-1:0] PH_DONE      = 5'd22;
    localparam logic [PHASE_W-1:0] PH_ERR       = 5'd23;

    // one result item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WHERE_W-1:0] where;
        logic [BYTE_W-1:0]  value;
        logic [ERR_W-1:0]   error_code;
        logic [CNT_W-1:0]   loaded_count;
    } t_result;

endpackage

// ===== src/tibd_parse.sv =====
// tibd_parse: byte-wise parser state machine of the tape image deframer
// holds the parse state and forms at most one result per accepted byte
// depends on tibd_pkg
module tibd_parse #(
    parameter int NAME_MAX_LEN = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic [tibd_pkg::BYTE_W-1:0]       i_byte,
    output logic                              o_res_valid,
    output tibd_pkg::t_result                 o_res
);

    logic [tibd_pkg::PHASE_W-1:0] r_phase,      n_phase;
    logic                         r_last,       n_last;
    logic [15:0]                  r_outer_size, n_outer_size;
    logic [15:0]                  r_inner_sum,  n_inner_sum;
    logic [tibd_pkg::LEFT_W-1:0]  r_left,       n_left;
    logic [7:0]                   r_low,        n_low;
    logic [15:0]                  r_baddr,      n_baddr;
    logic [15:0]                  r_first,      n_first;
    logic [tibd_pkg::CNT_W-1:0]   r_loaded,     n_loaded;
    logic [tibd_pkg::NPOS_W-1:0]  r_npos,       n_npos;

    logic [tibd_pkg::LEFT_W-1:0]  left_dec;
    logic [tibd_pkg::LEFT_W-1:0]  count_v;
    logic [15:0]                  chain_addr;

    assign left_dec   = r_left - tibd_pkg::LEFT_W'(1);
    assign count_v    = (i_byte == 8'd0) ? tibd_pkg::LEFT_W'(256)
                                         : tibd_pkg::LEFT_W'(i_byte);
    assign chain_addr = r_first + r_loaded;

    // next state and result for the byte on offer
    always_comb begin
        n_phase      = r_phase;
        n_last       = r_last;
        n_outer_size = r_outer_size;
        n_inner_sum  = r_inner_sum;
        n_left       = r_left;
        n_low        = r_low;
        n_baddr      = r_baddr;
        n_first      = r_first;
        n_loaded     = r_loaded;
        n_npos       = r_npos;
        o_res_valid  = 1'b0;
        o_res.kind       = tibd_pkg::KIND_ERROR;
        o_res.where      = '0;
        o_res.value      = '0;
        o_res.error_code = tibd_pkg::ERR_NONE;

        case (r_phase)
            tibd_pkg::PH_HDR: begin
                if (i_byte != tibd_pkg::BYTE_HEADER) begin
                    n_phase          = tibd_pkg::PH_ERR;
                    o_res_valid      = 1'b1;
                    o_res.error_code = tibd_pkg::ERR_HEADER;
                end else begin
                    n_phase = tibd_pkg::PH_LEN_L;
                end
            end
            tibd_pkg::PH_LEN_L: n_phase = tibd_pkg::PH_LEN_H;
            tibd_pkg::PH_LEN_H: n_phase = tibd_pkg::PH_OTYPE;
            tibd_pkg::PH_OTYPE: begin
                if (i_byte != tibd_pkg::BYTE_OUTER && i_byte != tibd_pkg::BYTE_OUTER_LAST) begin
                    n_phase          = tibd_pkg::PH_ERR;
                    o_res_valid      = 1'b1;
                    o_res.error_code = tibd_pkg::ERR_OUTER_TYPE;
                end else begin
                    n_last  = (i_byte == tibd_pkg::BYTE_OUTER_LAST);
                    n_phase = tibd_pkg::PH_OSIZE_L;
                end
            end
            tibd_pkg::PH_OSIZE_L: begin
                n_low   = i_byte;
                n_phase = tibd_pkg::PH_OSIZE_H;
            end
            tibd_pkg::PH_OSIZE_H: begin
                n_outer_size = {i_byte, r_low};
                n_inner_sum  = '0;
                n_phase      = tibd_pkg::PH_TTYPE;
            end
            tibd_pkg::PH_TTYPE: begin
                if (i_byte == tibd_pkg::BYTE_NAME_A || i_byte == tibd_pkg::BYTE_NAME_B) begin
                    n_phase = tibd_pkg::PH_NAME_IDX;
                end else if (i_byte == tibd_pkg::BYTE_DATA) begin
                    n_phase = tibd_pkg::PH_DATA_IDX;
                end else if (i_byte == tibd_pkg::BYTE_CLOSE) begin
                    n_phase = tibd_pkg::PH_CLOSE_IDX;
                end else begin
                    n_phase = tibd_pkg::PH_BAD_IDX;
                end
            end
            tibd_pkg::PH_BAD_IDX: begin
                n_phase          = tibd_pkg::PH_ERR;
                o_res_valid      = 1'b1;
                o_res.error_code = tibd_pkg::ERR_TAPE_TYPE;
            end
            tibd_pkg::PH_NAME_IDX: n_phase = tibd_pkg::PH_NAME_LEN;
            tibd_pkg::PH_NAME_LEN: begin
                if (i_byte > 8'(NAME_MAX_LEN)) begin
                    n_phase          = tibd_pkg::PH_ERR;
                    o_res_valid      = 1'b1;
                    o_res.error_code = tibd_pkg::ERR_NAME_LONG;
                end else begin
                    n_inner_sum = r_inner_sum + 16'(i_byte) + 16'd4;
                    n_left      = tibd_pkg::LEFT_W'(i_byte);
                    n_npos      = '0;
                    n_phase     = (i_byte == 8'd0) ? tibd_pkg::PH_NAME_CRC
                                                   : tibd_pkg::PH_NAME_CHR;
                end
            end
            tibd_pkg::PH_NAME_CHR: begin
                n_npos      = r_npos + tibd_pkg::NPOS_W'(1);
                n_left      = left_dec;
                if (left_dec == '0) begin
                    n_phase = tibd_pkg::PH_NAME_CRC;
                end
                o_res_valid = 1'b1;
                o_res.kind  = tibd_pkg::KIND_NAME_CHR;
                o_res.where = 16'(r_npos);
                o_res.value = i_byte;
            end
            tibd_pkg::PH_DATA_IDX: n_phase = tibd_pkg::PH_ADDR_L;
            tibd_pkg::PH_ADDR_L: begin
                n_low   = i_byte;
                n_phase = tibd_pkg::PH_ADDR_H;
            end
            tibd_pkg::PH_ADDR_H: begin
                n_baddr = {i_byte, r_low};
                n_phase = tibd_pkg::PH_COUNT;
            end
            tibd_pkg::PH_COUNT: begin
                if (r_loaded != '0 && chain_addr != r_baddr) begin
                    n_phase          = tibd_pkg::PH_ERR;
                    o_res_valid      = 1'b1;
                    o_res.error_code = tibd_pkg::ERR_GAP;
                end else begin
                    if (r_loaded == '0) begin
                        n_first = r_baddr;
                    end
                    n_inner_sum = r_inner_sum + 16'(count_v) + 16'd6;
                    n_left      = count_v;
                    n_phase     = tibd_pkg::PH_DATA_BYTE;
                end
            end
            tibd_pkg::PH_DATA_BYTE: begin
                n_baddr     = r_baddr + 16'd1;
                n_loaded    = r_loaded + tibd_pkg::CNT_W'(1);
                n_left      = left_dec;
                if (left_dec == '0) begin
                    n_phase = tibd_pkg::PH_DATA_CRC;
                end
                o_res_valid = 1'b1;
                o_res.kind  = tibd_pkg::KIND_DATA;
                o_res.where = r_baddr;
                o_res.value = i_byte;
            end
            tibd_pkg::PH_CLOSE_IDX: begin
                n_inner_sum = r_inner_sum + 16'd5;
                n_phase     = tibd_pkg::PH_RUN_L;
            end
            tibd_pkg::PH_RUN_L: begin
                n_low   = i_byte;
                n_phase = tibd_pkg::PH_RUN_H;
            end
            tibd_pkg::PH_RUN_H: begin
                n_phase     = tibd_pkg::PH_CLOSE_CRC;
                o_res_valid = 1'b1;
                o_res.kind  = tibd_pkg::KIND_RUN;
                o_res.where = {i_byte, r_low};
            end
            tibd_pkg::PH_NAME_CRC,
            tibd_pkg::PH_DATA_CRC,
            tibd_pkg::PH_CLOSE_CRC: begin
                // end of tape block: compare running sum with the outer size
                if (r_inner_sum < r_outer_size) begin
                    n_phase = tibd_pkg::PH_TTYPE;
                end else if (r_inner_sum > r_outer_size) begin
                    n_phase          = tibd_pkg::PH_ERR;
                    o_res_valid      = 1'b1;
                    o_res.error_code = tibd_pkg::ERR_OVERRUN;
                end else if (r_last) begin
                    n_phase     = tibd_pkg::PH_DONE;
                    o_res_valid = 1'b1;
                    o_res.kind  = tibd_pkg::KIND_FINISH;
                end else begin
                    n_phase = tibd_pkg::PH_OTYPE;
                end
            end
            default: begin
                // finished or failed: bytes are dropped
                n_phase = r_phase;
            end
        endcase

        o_res.loaded_count = n_loaded;
    end

    // parse state, updated on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tibd_pkg::PH_HDR;
            r_last       <= 1'b0;
            r_outer_size <= '0;
            r_inner_sum  <= '0;
            r_left       <= '0;
            r_low        <= '0;
            r_baddr      <= '0;
            r_first      <= '0;
            r_loaded     <= '0;
            r_npos       <= '0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_last       <= n_last;
            r_outer_size <= n_outer_size;
            r_inner_sum  <= n_inner_sum;
            r_left       <= n_left;
            r_low        <= n_low;
            r_baddr      <= n_baddr;
            r_first      <= n_first;
            r_loaded     <= n_loaded;
            r_npos       <= n_npos;
        end
    end

endmodule

// ===== src/tape_image_block_deframer.sv =====
// tape_image_block_deframer: top level, byte input, parser and result skid buffer
// depends on tibd_pkg and tibd_parse
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_byte
//  out     | output    | o_out_valid / i_out_ready  | o_kind o_where o_value
//          |           |                            | o_error_code o_loaded_count
//
// one byte is accepted per cycle unless the skid register is full; input ready
// drops only then. a result, if any, goes to the output register, or, while
// that register is held, to the skid register behind it, so a byte can be taken
// while a result waits. the parse state is a single registered phase machine
// updated once per byte. reset is synchronous and active low.
module tape_image_block_deframer #(
    parameter int NAME_MAX_LEN = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tibd_pkg::BYTE_W-1:0]     i_in_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tibd_pkg::KIND_W-1:0]     o_kind,
    output logic [tibd_pkg::WHERE_W-1:0]    o_where,
    output logic [tibd_pkg::BYTE_W-1:0]     o_value,
    output logic [tibd_pkg::ERR_W-1:0]      o_error_code,
    output logic [tibd_pkg::CNT_W-1:0]      o_loaded_count
);

    logic              take;
    logic              res_valid;
    tibd_pkg::t_result res;

    logic              r_out_valid;
    tibd_pkg::t_result r_out;
    logic              r_skid_valid;
    tibd_pkg::t_result r_skid;
    logic              out_free;

    assign o_in_ready = !r_skid_valid;
    assign take       = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || i_out_ready;

    tibd_parse #(
        .NAME_MAX_LEN (NAME_MAX_LEN)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= take && res_valid;
            end
        end else if (take && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload moves with the valid bits, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (take && res_valid) begin
                r_out <= res;
            end
        end else if (take && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_where        = r_out.where;
    assign o_value        = r_out.value;
    assign o_error_code   = r_out.error_code;
    assign o_loaded_count = r_out.loaded_count;

endmodule
